// ----- hdl/ssv_pkg.sv -----
// Package for the syllable spelling validator: token tables, class
// compatibility tables, channel word layouts and the row-matching function.
// Depends on nothing; every other file but ssv_stream_if imports it.
package ssv_pkg;

    localparam int CpWidth    = 21;
    localparam int CharsWidth = 63;
    localparam int LenWidth   = 3;
    localparam int OnsetRows  = 5;
    localparam int NucRows    = 8;
    localparam int CodaRows   = 5;

    typedef logic [CpWidth-1:0]    cp_t;
    typedef logic [CharsWidth-1:0] chars_t;
    typedef logic [LenWidth-1:0]   len_t;

    localparam cp_t A_CIRC  = 21'h0000E2;
    localparam cp_t A_BREVE = 21'h000103;
    localparam cp_t E_CIRC  = 21'h0000EA;
    localparam cp_t O_CIRC  = 21'h0000F4;
    localparam cp_t O_HORN  = 21'h0001A1;
    localparam cp_t U_HORN  = 21'h0001B0;
    localparam cp_t D_BAR   = 21'h000111;
    localparam cp_t NO_CP   = 21'h000000;

    // Input word: the three parts of one syllable and the completeness flag.
    typedef struct packed {
        chars_t onset_chars;
        len_t   onset_len;
        chars_t nucleus_chars;
        len_t   nucleus_len;
        chars_t coda_chars;
        len_t   coda_len;
        logic   word_finished;
    } syl_word_t;

    // Result word: validity and the three class masks.
    typedef struct packed {
        logic                 is_valid;
        logic [OnsetRows-1:0] onset_class_mask;
        logic [NucRows-1:0]   nucleus_class_mask;
        logic [CodaRows-1:0]  coda_class_mask;
    } verdict_t;

    // One token row: class, length and up to three characters.
    typedef struct packed {
        logic [2:0] row;
        logic [1:0] len;
        cp_t        c0;
        cp_t        c1;
        cp_t        c2;
    } token_t;

    // Item as it passes from the front part to the back part.
    typedef struct packed {
        logic [OnsetRows-1:0] onset_mask;
        logic [NucRows-1:0]   nucleus_mask;
        logic [CodaRows-1:0]  coda_mask;
        logic                 onset_present;
        logic                 nucleus_present;
        logic                 coda_present;
    } class_item_t;

    localparam int OnsetCount = 33;
    localparam int NucCount   = 60;
    localparam int CodaCount  = 10;

    function automatic token_t tk(input int r, input int l, input cp_t a,
                                  input cp_t b, input cp_t c);
        token_t t;
        t.row = r[2:0];
        t.len = l[1:0];
        t.c0  = a;
        t.c1  = b;
        t.c2  = c;
        return t;
    endfunction

    function automatic cp_t ch(input byte b);
        return cp_t'(b);
    endfunction

    function automatic token_t onset_token(input int k);
        token_t t;
        t = tk(0, 0, NO_CP, NO_CP, NO_CP);
        case (k)
            0:  t = tk(0, 1, ch("b"), NO_CP, NO_CP);
            1:  t = tk(0, 1, ch("d"), NO_CP, NO_CP);
            2:  t = tk(0, 1, D_BAR, NO_CP, NO_CP);
            3:  t = tk(0, 1, ch("g"), NO_CP, NO_CP);
            4:  t = tk(0, 2, ch("g"), ch("h"), NO_CP);
            5:  t = tk(0, 1, ch("m"), NO_CP, NO_CP);
            6:  t = tk(0, 1, ch("n"), NO_CP, NO_CP);
            7:  t = tk(0, 2, ch("n"), ch("h"), NO_CP);
            8:  t = tk(0, 1, ch("p"), NO_CP, NO_CP);
            9:  t = tk(0, 2, ch("p"), ch("h"), NO_CP);
            10: t = tk(0, 1, ch("r"), NO_CP, NO_CP);
            11: t = tk(0, 1, ch("s"), NO_CP, NO_CP);
            12: t = tk(0, 1, ch("t"), NO_CP, NO_CP);
            13: t = tk(0, 2, ch("t"), ch("r"), NO_CP);
            14: t = tk(0, 1, ch("v"), NO_CP, NO_CP);
            15: t = tk(0, 1, ch("z"), NO_CP, NO_CP);
            16: t = tk(1, 1, ch("c"), NO_CP, NO_CP);
            17: t = tk(1, 1, ch("h"), NO_CP, NO_CP);
            18: t = tk(1, 1, ch("k"), NO_CP, NO_CP);
            19: t = tk(1, 2, ch("k"), ch("h"), NO_CP);
            20: t = tk(1, 2, ch("k"), ch("r"), NO_CP);
            21: t = tk(1, 2, ch("q"), ch("u"), NO_CP);
            22: t = tk(1, 2, ch("t"), ch("h"), NO_CP);
            23: t = tk(2, 2, ch("c"), ch("h"), NO_CP);
            24: t = tk(2, 2, ch("g"), ch("i"), NO_CP);
            25: t = tk(2, 1, ch("l"), NO_CP, NO_CP);
            26: t = tk(2, 2, ch("n"), ch("g"), NO_CP);
            27: t = tk(2, 3, ch("n"), ch("g"), ch("h"));
            28: t = tk(2, 1, ch("x"), NO_CP, NO_CP);
            29: t = tk(3, 1, ch("b"), NO_CP, NO_CP);
            30: t = tk(3, 1, D_BAR, NO_CP, NO_CP);
            31: t = tk(3, 1, ch("l"), NO_CP, NO_CP);
            32: t = tk(4, 1, ch("h"), NO_CP, NO_CP);
            default: t = tk(0, 0, NO_CP, NO_CP, NO_CP);
        endcase
        return t;
    endfunction

    function automatic token_t nucleus_token(input int k);
        token_t t;
        t = tk(0, 0, NO_CP, NO_CP, NO_CP);
        case (k)
            0:  t = tk(0, 1, E_CIRC, NO_CP, NO_CP);
            1:  t = tk(0, 1, ch("i"), NO_CP, NO_CP);
            2:  t = tk(0, 2, ch("u"), ch("a"), NO_CP);
            3:  t = tk(0, 2, ch("u"), E_CIRC, NO_CP);
            4:  t = tk(0, 2, ch("u"), ch("y"), NO_CP);
            5:  t = tk(0, 1, ch("y"), NO_CP, NO_CP);
            6:  t = tk(1, 1, ch("a"), NO_CP, NO_CP);
            7:  t = tk(1, 2, ch("i"), E_CIRC, NO_CP);
            8:  t = tk(1, 2, ch("o"), ch("a"), NO_CP);
            9:  t = tk(1, 3, ch("u"), ch("y"), E_CIRC);
            10: t = tk(1, 2, ch("y"), E_CIRC, NO_CP);
            11: t = tk(2, 1, A_CIRC, NO_CP, NO_CP);
            12: t = tk(2, 1, A_BREVE, NO_CP, NO_CP);
            13: t = tk(2, 1, ch("e"), NO_CP, NO_CP);
            14: t = tk(2, 1, ch("o"), NO_CP, NO_CP);
            15: t = tk(2, 2, ch("o"), ch("o"), NO_CP);
            16: t = tk(2, 1, O_CIRC, NO_CP, NO_CP);
            17: t = tk(2, 1, O_HORN, NO_CP, NO_CP);
            18: t = tk(2, 2, ch("o"), ch("e"), NO_CP);
            19: t = tk(2, 1, ch("u"), NO_CP, NO_CP);
            20: t = tk(2, 1, U_HORN, NO_CP, NO_CP);
            21: t = tk(2, 2, ch("u"), A_CIRC, NO_CP);
            22: t = tk(2, 2, ch("u"), O_CIRC, NO_CP);
            23: t = tk(2, 2, U_HORN, O_HORN, NO_CP);
            24: t = tk(3, 2, ch("o"), A_BREVE, NO_CP);
            25: t = tk(4, 2, ch("u"), O_HORN, NO_CP);
            26: t = tk(5, 2, ch("a"), ch("i"), NO_CP);
            27: t = tk(5, 2, ch("a"), ch("o"), NO_CP);
            28: t = tk(5, 2, ch("a"), ch("u"), NO_CP);
            29: t = tk(5, 2, A_CIRC, ch("u"), NO_CP);
            30: t = tk(5, 2, ch("a"), ch("y"), NO_CP);
            31: t = tk(5, 2, A_CIRC, ch("y"), NO_CP);
            32: t = tk(5, 2, ch("e"), ch("o"), NO_CP);
            33: t = tk(5, 2, E_CIRC, ch("u"), NO_CP);
            34: t = tk(5, 2, ch("i"), ch("a"), NO_CP);
            35: t = tk(5, 3, ch("i"), E_CIRC, ch("u"));
            36: t = tk(5, 2, ch("i"), ch("u"), NO_CP);
            37: t = tk(5, 3, ch("o"), ch("a"), ch("i"));
            38: t = tk(5, 3, ch("o"), ch("a"), ch("o"));
            39: t = tk(5, 3, ch("o"), ch("a"), ch("y"));
            40: t = tk(5, 3, ch("o"), ch("e"), ch("o"));
            41: t = tk(5, 2, ch("o"), ch("i"), NO_CP);
            42: t = tk(5, 2, O_CIRC, ch("i"), NO_CP);
            43: t = tk(5, 2, O_HORN, ch("i"), NO_CP);
            44: t = tk(5, 2, U_HORN, ch("a"), NO_CP);
            45: t = tk(5, 3, ch("u"), A_CIRC, ch("y"));
            46: t = tk(5, 2, ch("u"), ch("i"), NO_CP);
            47: t = tk(5, 2, U_HORN, ch("i"), NO_CP);
            48: t = tk(5, 3, ch("u"), O_CIRC, ch("i"));
            49: t = tk(5, 3, U_HORN, O_HORN, ch("i"));
            50: t = tk(5, 3, U_HORN, O_HORN, ch("u"));
            51: t = tk(5, 2, U_HORN, ch("u"), NO_CP);
            52: t = tk(5, 3, ch("u"), ch("y"), ch("a"));
            53: t = tk(5, 3, ch("u"), ch("y"), ch("u"));
            54: t = tk(5, 3, ch("u"), E_CIRC, ch("u"));
            55: t = tk(5, 3, ch("y"), E_CIRC, ch("u"));
            56: t = tk(6, 1, A_BREVE, NO_CP, NO_CP);
            57: t = tk(6, 1, ch("u"), NO_CP, NO_CP);
            58: t = tk(7, 1, ch("i"), NO_CP, NO_CP);
            59: t = tk(0, 0, NO_CP, NO_CP, NO_CP);
            default: t = tk(0, 0, NO_CP, NO_CP, NO_CP);
        endcase
        return t;
    endfunction

    function automatic token_t coda_token(input int k);
        token_t t;
        t = tk(0, 0, NO_CP, NO_CP, NO_CP);
        case (k)
            0: t = tk(0, 2, ch("c"), ch("h"), NO_CP);
            1: t = tk(0, 2, ch("n"), ch("h"), NO_CP);
            2: t = tk(1, 1, ch("c"), NO_CP, NO_CP);
            3: t = tk(1, 2, ch("n"), ch("g"), NO_CP);
            4: t = tk(2, 1, ch("m"), NO_CP, NO_CP);
            5: t = tk(2, 1, ch("n"), NO_CP, NO_CP);
            6: t = tk(2, 1, ch("p"), NO_CP, NO_CP);
            7: t = tk(2, 1, ch("t"), NO_CP, NO_CP);
            8: t = tk(3, 1, ch("k"), NO_CP, NO_CP);
            9: t = tk(4, 1, ch("c"), NO_CP, NO_CP);
            default: t = tk(0, 0, NO_CP, NO_CP, NO_CP);
        endcase
        return t;
    endfunction

    // Allowed nucleus classes per onset class.
    function automatic logic [NucRows-1:0] cv_allow(input int i);
        logic [NucRows-1:0] m;
        case (i)
            0: m = 8'h27;
            1: m = 8'h3F;
            2: m = 8'h2F;
            3: m = 8'h40;
            4: m = 8'h80;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    // Allowed coda classes per nucleus class.
    function automatic logic [CodaRows-1:0] vc_allow(input int i);
        logic [CodaRows-1:0] m;
        case (i)
            0: m = 5'h05;
            1: m = 5'h07;
            2: m = 5'h06;
            3: m = 5'h06;
            6: m = 5'h08;
            7: m = 5'h10;
            default: m = 5'h00;
        endcase
        return m;
    endfunction

    // Diacritic folding of a token character.
    function automatic cp_t toneless(input cp_t c);
        cp_t r;
        case (c)
            A_CIRC, A_BREVE: r = ch("a");
            E_CIRC:          r = ch("e");
            O_CIRC, O_HORN:  r = ch("o");
            U_HORN:          r = ch("u");
            D_BAR:           r = ch("d");
            default:         r = c;
        endcase
        return r;
    endfunction

    // Does one token row match the part under the given rules?
    function automatic logic token_match(input token_t t, input chars_t chars,
                                         input len_t len, input logic full,
                                         input logic complete);
        cp_t  p [3];
        cp_t  tc [3];
        logic ok;
        p[0]  = chars[CpWidth-1:0];
        p[1]  = chars[2*CpWidth-1:CpWidth];
        p[2]  = chars[3*CpWidth-1:2*CpWidth];
        tc[0] = t.c0;
        tc[1] = t.c1;
        tc[2] = t.c2;
        ok = (len != 3'd0) && (len <= 3'd3) && (t.len != 2'd0);
        if ({1'b0, t.len} < len || (full && {1'b0, t.len} > len))
            ok = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (i < int'(len) && p[i] != tc[i] && (complete || toneless(tc[i]) != p[i]))
                ok = 1'b0;
        end
        return ok;
    endfunction

endpackage

// ----- hdl/ssv_stream_if.sv -----
// Valid/ready channel interface carrying a payload of parameterised type.
// Depends on nothing.
interface ssv_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/ssv_front.sv -----
// Front part: accepts a syllable word, matches its three parts against the
// token tables and registers the class masks. Depends on ssv_pkg.
module ssv_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  ssv_pkg::chars_t         onset_chars,
    input  ssv_pkg::len_t           onset_len,
    input  ssv_pkg::chars_t         nucleus_chars,
    input  ssv_pkg::len_t           nucleus_len,
    input  ssv_pkg::chars_t         coda_chars,
    input  ssv_pkg::len_t           coda_len,
    input  logic                    word_finished,
    output logic                    out_valid,
    input  logic                    out_ready,
    output ssv_pkg::class_item_t    out_item
);
    import ssv_pkg::*;

    logic        valid_reg;
    class_item_t item_reg;
    class_item_t item_next;

    // The stage takes a word whenever it is empty or being drained.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // Parallel matching of every token row.
    always_comb
    begin
        logic n_full;
        logic c_full;
        n_full = word_finished || (nucleus_len != 3'd0);
        c_full = word_finished || (coda_len != 3'd0);
        item_next = '0;
        for (int k = 0; k < OnsetCount; k++)
        begin
            if (token_match(onset_token(k), onset_chars, onset_len, n_full, 1'b1))
                item_next.onset_mask[onset_token(k).row] = 1'b1;
        end
        for (int k = 0; k < NucCount; k++)
        begin
            if (token_match(nucleus_token(k), nucleus_chars, nucleus_len, c_full,
                            word_finished))
                item_next.nucleus_mask[nucleus_token(k).row] = 1'b1;
        end
        for (int k = 0; k < CodaCount; k++)
        begin
            if (token_match(coda_token(k), coda_chars, coda_len, word_finished, 1'b1))
                item_next.coda_mask[coda_token(k).row] = 1'b1;
        end
        item_next.onset_present   = onset_len != 3'd0;
        item_next.nucleus_present = nucleus_len != 3'd0;
        item_next.coda_present    = coda_len != 3'd0;
    end

    // Stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= item_next;
    end

    // An empty part never yields a class.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !item_reg.onset_present |-> item_reg.onset_mask == '0)
        else $error("onset mask set for an empty onset");
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |=> valid_reg && $stable(item_reg))
        else $error("front stage lost a stalled word");
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !item_reg.coda_present |-> item_reg.coda_mask == '0)
        else $error("coda mask set for an empty coda");
endmodule

// ----- hdl/ssv_queue.sv -----
// Two-entry queue between the front and back parts.
// Depends on ssv_pkg.
module ssv_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ssv_pkg::class_item_t in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ssv_pkg::class_item_t out_item
);
    import ssv_pkg::*;

    class_item_t mem [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push;
    logic        pop;

    assign in_ready  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_item  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= in_item;
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= 2'd2)
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");
    assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count missed a push");
endmodule

// ----- hdl/ssv_back.sv -----
// Back part: checks class compatibility and holds the result word in an
// output register. Depends on ssv_pkg.
module ssv_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  ssv_pkg::class_item_t               in_item,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               is_valid,
    output logic [ssv_pkg::OnsetRows-1:0]      onset_class_mask,
    output logic [ssv_pkg::NucRows-1:0]        nucleus_class_mask,
    output logic [ssv_pkg::CodaRows-1:0]       coda_class_mask
);
    import ssv_pkg::*;

    logic                 valid_reg;
    logic                 ok_reg;
    logic                 ok_next;
    logic [OnsetRows-1:0] om_reg;
    logic [NucRows-1:0]   nm_reg;
    logic [CodaRows-1:0]  cm_reg;

    assign in_ready           = !valid_reg || out_ready;
    assign out_valid          = valid_reg;
    assign is_valid           = ok_reg;
    assign onset_class_mask   = om_reg;
    assign nucleus_class_mask = nm_reg;
    assign coda_class_mask    = cm_reg;

    // Validity from the masks and the compatibility tables.
    always_comb
    begin
        logic cv;
        logic vc;
        cv = 1'b0;
        vc = 1'b0;
        for (int i = 0; i < OnsetRows; i++)
        begin
            if (in_item.onset_mask[i] && ((cv_allow(i) & in_item.nucleus_mask) != '0))
                cv = 1'b1;
        end
        for (int i = 0; i < NucRows; i++)
        begin
            if (in_item.nucleus_mask[i] && ((vc_allow(i) & in_item.coda_mask) != '0))
                vc = 1'b1;
        end
        if (in_item.onset_mask == '0)
            cv = 1'b1;
        if (in_item.coda_mask == '0)
            vc = 1'b1;
        if ((in_item.onset_present && in_item.onset_mask == '0)
            || (in_item.nucleus_present && in_item.nucleus_mask == '0)
            || (in_item.coda_present && in_item.coda_mask == '0))
            ok_next = 1'b0;
        else if (in_item.nucleus_mask == '0)
            ok_next = in_item.onset_mask != '0;
        else
            ok_next = cv && vc;
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // Output word.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ok_reg <= ok_next;
            om_reg <= in_item.onset_mask;
            nm_reg <= in_item.nucleus_mask;
            cm_reg <= in_item.coda_mask;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && ok_reg |-> (om_reg != '0 || nm_reg != '0))
        else $error("valid answer with no matched class");
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |=> valid_reg && $stable(ok_reg))
        else $error("stalled result changed");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg)
        else $error("accepted word not presented");
endmodule

// ----- hdl/syllable_spelling_validator_core.sv -----
// Syllable spelling validator: the result word is offered once the input word
// has passed the match register, a queue entry and the check register, in that
// order; throughput one word per cycle while the output is not stalled, set by
// the parallel table compare in the front stage.
// Reset (rst_n, asynchronous) empties all stages; there is no other state.
// Depends on ssv_pkg, ssv_stream_if, ssv_front, ssv_queue and ssv_back.
module syllable_spelling_validator_core (
    input  logic         clk,
    input  logic         rst_n,
    ssv_stream_if.sink   in_ch,
    ssv_stream_if.source out_ch
);
    import ssv_pkg::*;

    logic        fq_valid;
    logic        fq_ready;
    class_item_t fq_item;
    logic        qb_valid;
    logic        qb_ready;
    class_item_t qb_item;

    // Front: classify.
    ssv_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_ch.valid),
        .in_ready      (in_ch.ready),
        .onset_chars   (in_ch.data.onset_chars),
        .onset_len     (in_ch.data.onset_len),
        .nucleus_chars (in_ch.data.nucleus_chars),
        .nucleus_len   (in_ch.data.nucleus_len),
        .coda_chars    (in_ch.data.coda_chars),
        .coda_len      (in_ch.data.coda_len),
        .word_finished (in_ch.data.word_finished),
        .out_valid     (fq_valid),
        .out_ready     (fq_ready),
        .out_item      (fq_item)
    );

    // Decoupling queue.
    ssv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    // Back: compatibility check and result register.
    ssv_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (qb_valid),
        .in_ready           (qb_ready),
        .in_item            (qb_item),
        .out_valid          (out_ch.valid),
        .out_ready          (out_ch.ready),
        .is_valid           (out_ch.data.is_valid),
        .onset_class_mask   (out_ch.data.onset_class_mask),
        .nucleus_class_mask (out_ch.data.nucleus_class_mask),
        .coda_class_mask    (out_ch.data.coda_class_mask)
    );
endmodule
